### design/ccld_pkg.sv
// Shared types, codes, keyword tables and helper functions of the console line decoder.
`timescale 1ns / 1ps
`default_nettype none

package ccld_pkg;

  // Default sizes
  localparam int LINE_MAX_DEF  = 256;
  localparam int TOKEN_BUF_DEF = 16;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Outcome codes
  localparam logic [3:0] OC_BLANK       = 4'd0;
  localparam logic [3:0] OC_TOO_LONG    = 4'd1;
  localparam logic [3:0] OC_HELP        = 4'd2;
  localparam logic [3:0] OC_STATUS      = 4'd3;
  localparam logic [3:0] OC_GET_STATUS  = 4'd4;
  localparam logic [3:0] OC_RULE_ADD    = 4'd5;
  localparam logic [3:0] OC_RULE_DELETE = 4'd6;
  localparam logic [3:0] OC_RULE_ENABLE = 4'd7;
  localparam logic [3:0] OC_RULE_DISABLE = 4'd8;
  localparam logic [3:0] OC_RULE_LIST   = 4'd9;
  localparam logic [3:0] OC_RULE_TEST   = 4'd10;
  localparam logic [3:0] OC_UNKNOWN     = 4'd11;
  localparam logic [3:0] OC_MISSING_SUB = 4'd12;
  localparam logic [3:0] OC_UNKNOWN_SUB = 4'd13;

  // Keywords, left aligned: character i sits at byte 9-i
  typedef logic [9:0][7:0] kw_t;

  localparam int CMD_NUM = 4;
  localparam int SUB_NUM = 6;

  localparam int KW_RULE       = 0;
  localparam int KW_STATUS     = 1;
  localparam int KW_GET_STATUS = 2;
  localparam int KW_HELP       = 3;

  localparam int SW_ADD     = 0;
  localparam int SW_DELETE  = 1;
  localparam int SW_ENABLE  = 2;
  localparam int SW_DISABLE = 3;
  localparam int SW_LIST    = 4;
  localparam int SW_TEST    = 5;

  localparam kw_t CMD_KW [CMD_NUM] = '{
    {"RULE", 48'h0}, {"STATUS", 32'h0}, {"GET_STATUS"}, {"HELP", 48'h0}
  };
  localparam logic [3:0] CMD_LEN [CMD_NUM] = '{4'd4, 4'd6, 4'd10, 4'd4};

  localparam kw_t SUB_KW [SUB_NUM] = '{
    {"ADD", 56'h0}, {"DELETE", 32'h0}, {"ENABLE", 32'h0},
    {"DISABLE", 24'h0}, {"LIST", 48'h0}, {"TEST", 48'h0}
  };
  localparam logic [3:0] SUB_LEN [SUB_NUM] = '{4'd3, 4'd6, 4'd6, 4'd7, 4'd4, 4'd4};

  // Line parse phases
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_CMD,
    PH_GAP1,
    PH_SUB,
    PH_GAP2,
    PH_ARG
  } phase_t;

  // Decimal argument evaluation
  typedef enum logic [1:0] {
    NUM_WS,
    NUM_SIGNED,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  typedef struct packed {
    num_phase_t  phase;
    logic        neg;
    logic [31:0] mag;
  } num_t;

  localparam logic [34:0] MAG_SAT = 35'h0_8000_0000;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LC_A && c <= CH_LC_Z) r = c - CASE_GAP;
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // True if keyword character idx exists and equals c
  function automatic logic kw_hit(input kw_t kw, input logic [3:0] kw_len,
                                  input logic [5:0] idx, input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (idx < {2'b00, kw_len}) r = (kw[4'd9 - idx[3:0]] == c);
    return r;
  endfunction

  // One byte of the strtol-style scan
  function automatic num_t num_step(input num_t s, input logic [7:0] c);
    num_t        r;
    logic        digit;
    logic [34:0] t;
    r     = s;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    t     = ({3'b000, s.mag} << 3) + ({3'b000, s.mag} << 1) + {31'd0, 4'(c - CH_ZERO)};
    if (t > MAG_SAT) t = MAG_SAT;
    case (s.phase)
      NUM_WS: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          r.phase = NUM_WS;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          r.neg   = (c == CH_MINUS);
          r.phase = NUM_SIGNED;
        end else if (digit) begin
          r.mag   = t[31:0];
          r.phase = NUM_DIGITS;
        end else begin
          r.phase = NUM_DONE;
        end
      end
      NUM_SIGNED, NUM_DIGITS: begin
        if (digit) begin
          r.mag   = t[31:0];
          r.phase = NUM_DIGITS;
        end else begin
          r.phase = NUM_DONE;
        end
      end
      default: r.phase = NUM_DONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/console_command_line_decoder.sv
// Console command line decoder: per-byte line parser with registered result.
//
//   channel | direction | ports                                    | moves
//   --------+-----------+------------------------------------------+--------------------------
//   in_     | input     | in_valid, in_ready, in_rx_byte            | one received byte
//   out_    | output    | out_valid, out_ready, out_outcome, ...    | one line outcome
//
// One byte per cycle while in_ready is high. Each byte updates the running keyword match
// masks, token counters and the decimal scan in a single pass; a CR, or an LF not after
// a CR, loads the outcome register, visible the cycle after that byte is taken.
// Reset (rst_n low, synchronous) returns to the start of a line with no CR seen.
// in_ready drops only while a held outcome is not being taken by out_ready.
`timescale 1ns / 1ps
`default_nettype none

module console_command_line_decoder #(
  parameter int LINE_MAX  = ccld_pkg::LINE_MAX_DEF,
  parameter int TOKEN_BUF = ccld_pkg::TOKEN_BUF_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              out_outcome,
  output logic                    out_arg_present,
  output logic [7:0]              out_arg_start,
  output logic [7:0]              out_arg_length,
  output logic signed [31:0]      out_arg_number,
  output logic [7:0]              out_line_length
);

  localparam int CNT_W = $clog2(LINE_MAX);
  localparam int TOK_W = $clog2(TOKEN_BUF);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_MAX - 1);
  localparam logic [TOK_W-1:0] TOK_CUT  = TOK_W'(TOKEN_BUF - 1);

  // Parse state
  ccld_pkg::phase_t                 phase_r, phase_nxt;
  logic                             prev_cr_r, prev_cr_nxt;
  logic                             overlong_r, overlong_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [CNT_W-1:0]                 lne_r, lne_nxt;
  logic [CNT_W-1:0]                 arg_off_r, arg_off_nxt;
  logic [TOK_W-1:0]                 cmd_len_r, cmd_len_nxt;
  logic [TOK_W-1:0]                 sub_len_r, sub_len_nxt;
  logic [ccld_pkg::CMD_NUM-1:0]     cmd_mask_r, cmd_mask_nxt;
  logic [ccld_pkg::SUB_NUM-1:0]     sub_mask_r, sub_mask_nxt;
  ccld_pkg::num_t                   num_r, num_nxt;

  // Result register
  logic                             out_valid_r, out_valid_nxt;
  logic [3:0]                       outcome_r, outcome_nxt;
  logic                             arg_present_r, arg_present_nxt;
  logic [7:0]                       arg_start_r, arg_start_nxt;
  logic [7:0]                       arg_length_r, arg_length_nxt;
  logic [31:0]                      arg_number_r, arg_number_nxt;
  logic [7:0]                       line_length_r, line_length_nxt;

  // Combinational helpers
  logic                             fire, is_cr, is_lf, swallow, line_end, blank;
  logic [7:0]                       uc;
  logic [TOK_W-1:0]                 cmd_idx, sub_idx, cmd_inc, sub_inc;
  logic [ccld_pkg::CMD_NUM-1:0]     cmd_hit, cmd_match, cmd_base;
  logic [ccld_pkg::SUB_NUM-1:0]     sub_hit, sub_match, sub_base;
  logic                             cmd_rule, sub_seen;
  logic [CNT_W-1:0]                 arg_at;
  ccld_pkg::num_t                   num_init, num_from, num_stepped;
  logic [31:0]                      num_value;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  assign is_cr    = (in_rx_byte == ccld_pkg::CH_CR);
  assign is_lf    = (in_rx_byte == ccld_pkg::CH_LF);
  assign swallow  = is_lf && prev_cr_r;
  assign line_end = (is_cr || is_lf) && !swallow;
  assign blank    = ccld_pkg::is_blank(in_rx_byte);
  assign uc       = ccld_pkg::upcase(in_rx_byte);

  // Token character positions; a token starts from the idle phase before it
  assign cmd_idx  = (phase_r == ccld_pkg::PH_LEAD) ? '0 : cmd_len_r;
  assign sub_idx  = (phase_r == ccld_pkg::PH_GAP1) ? '0 : sub_len_r;
  assign cmd_inc  = cmd_idx + TOK_W'(1);
  assign sub_inc  = sub_idx + TOK_W'(1);
  assign cmd_base = (phase_r == ccld_pkg::PH_LEAD) ? '1 : cmd_mask_r;
  assign sub_base = (phase_r == ccld_pkg::PH_GAP1) ? '1 : sub_mask_r;

  // Keyword comparators and whole-token matches
  always_comb begin
    for (int k = 0; k < ccld_pkg::CMD_NUM; k++) begin
      cmd_hit[k]   = ccld_pkg::kw_hit(ccld_pkg::CMD_KW[k], ccld_pkg::CMD_LEN[k],
                                      6'(cmd_idx), uc);
      cmd_match[k] = cmd_mask_r[k] && (6'(cmd_len_r) == 6'(ccld_pkg::CMD_LEN[k]));
    end
    for (int k = 0; k < ccld_pkg::SUB_NUM; k++) begin
      sub_hit[k]   = ccld_pkg::kw_hit(ccld_pkg::SUB_KW[k], ccld_pkg::SUB_LEN[k],
                                      6'(sub_idx), uc);
      sub_match[k] = sub_mask_r[k] && (6'(sub_len_r) == 6'(ccld_pkg::SUB_LEN[k]));
    end
  end

  assign cmd_rule = cmd_match[ccld_pkg::KW_RULE];
  assign sub_seen = (phase_r == ccld_pkg::PH_SUB) || (phase_r == ccld_pkg::PH_GAP2) ||
                    ((phase_r == ccld_pkg::PH_ARG) && cmd_rule);
  assign arg_at   = (phase_r == ccld_pkg::PH_ARG) ? arg_off_r : lne_r;

  // Decimal scan: restart on the first argument byte
  assign num_init    = '{phase: ccld_pkg::NUM_WS, neg: 1'b0, mag: 32'd0};
  assign num_from    = (phase_r == ccld_pkg::PH_ARG) ? num_r : num_init;
  assign num_stepped = ccld_pkg::num_step(num_from, in_rx_byte);
  assign num_value   = num_r.neg ? 32'(32'd0 - num_r.mag) :
                       (num_r.mag[31] ? 32'h7FFF_FFFF : num_r.mag);

  // Next state and result
  always_comb begin
    phase_nxt       = phase_r;
    prev_cr_nxt     = prev_cr_r;
    overlong_nxt    = overlong_r;
    count_nxt       = count_r;
    lne_nxt         = lne_r;
    arg_off_nxt     = arg_off_r;
    cmd_len_nxt     = cmd_len_r;
    sub_len_nxt     = sub_len_r;
    cmd_mask_nxt    = cmd_mask_r;
    sub_mask_nxt    = sub_mask_r;
    num_nxt         = num_r;

    out_valid_nxt   = out_valid_r && !out_ready;
    outcome_nxt     = outcome_r;
    arg_present_nxt = arg_present_r;
    arg_start_nxt   = arg_start_r;
    arg_length_nxt  = arg_length_r;
    arg_number_nxt  = arg_number_r;
    line_length_nxt = line_length_r;

    if (fire) begin
      if (swallow) begin
        prev_cr_nxt = 1'b0;
      end else if (line_end) begin
        // Line complete: load the result and start a fresh line
        prev_cr_nxt     = is_cr;
        out_valid_nxt   = 1'b1;
        outcome_nxt     = ccld_pkg::OC_BLANK;
        arg_present_nxt = 1'b0;
        arg_start_nxt   = '0;
        arg_length_nxt  = '0;
        arg_number_nxt  = '0;
        line_length_nxt = '0;
        if (overlong_r) begin
          outcome_nxt = ccld_pkg::OC_TOO_LONG;
        end else if (phase_r != ccld_pkg::PH_LEAD) begin
          if (!cmd_rule) begin
            if (cmd_match[ccld_pkg::KW_STATUS])          outcome_nxt = ccld_pkg::OC_STATUS;
            else if (cmd_match[ccld_pkg::KW_GET_STATUS]) outcome_nxt = ccld_pkg::OC_GET_STATUS;
            else if (cmd_match[ccld_pkg::KW_HELP])       outcome_nxt = ccld_pkg::OC_HELP;
            else                                         outcome_nxt = ccld_pkg::OC_UNKNOWN;
          end else if (!sub_seen) begin
            outcome_nxt = ccld_pkg::OC_MISSING_SUB;
          end else begin
            if (sub_match[ccld_pkg::SW_ADD])          outcome_nxt = ccld_pkg::OC_RULE_ADD;
            else if (sub_match[ccld_pkg::SW_DELETE])  outcome_nxt = ccld_pkg::OC_RULE_DELETE;
            else if (sub_match[ccld_pkg::SW_ENABLE])  outcome_nxt = ccld_pkg::OC_RULE_ENABLE;
            else if (sub_match[ccld_pkg::SW_DISABLE]) outcome_nxt = ccld_pkg::OC_RULE_DISABLE;
            else if (sub_match[ccld_pkg::SW_LIST])    outcome_nxt = ccld_pkg::OC_RULE_LIST;
            else if (sub_match[ccld_pkg::SW_TEST])    outcome_nxt = ccld_pkg::OC_RULE_TEST;
            else                                      outcome_nxt = ccld_pkg::OC_UNKNOWN_SUB;
          end
          arg_present_nxt = (phase_r == ccld_pkg::PH_ARG);
          arg_start_nxt   = 8'(arg_at);
          arg_length_nxt  = 8'(lne_r - arg_at);
          arg_number_nxt  = (phase_r == ccld_pkg::PH_ARG) ? num_value : 32'd0;
          line_length_nxt = 8'(lne_r);
        end
        phase_nxt    = ccld_pkg::PH_LEAD;
        overlong_nxt = 1'b0;
        count_nxt    = '0;
        lne_nxt      = '0;
        arg_off_nxt  = '0;
        cmd_len_nxt  = '0;
        sub_len_nxt  = '0;
        cmd_mask_nxt = '1;
        sub_mask_nxt = '1;
        num_nxt      = num_init;
      end else if (count_r >= CNT_LAST) begin
        // No room left in the line: drop the byte
        prev_cr_nxt  = 1'b0;
        overlong_nxt = 1'b1;
      end else begin
        prev_cr_nxt = 1'b0;
        count_nxt   = count_r + CNT_W'(1);
        if (!blank) lne_nxt = count_r + CNT_W'(1);
        unique case (phase_r)
          ccld_pkg::PH_LEAD, ccld_pkg::PH_CMD: begin
            if (!blank) begin
              cmd_mask_nxt = cmd_base & cmd_hit;
              cmd_len_nxt  = cmd_inc;
              phase_nxt    = (cmd_inc == TOK_CUT) ? ccld_pkg::PH_GAP1 : ccld_pkg::PH_CMD;
            end else if (phase_r == ccld_pkg::PH_CMD) begin
              phase_nxt = ccld_pkg::PH_GAP1;
            end
          end
          ccld_pkg::PH_GAP1: begin
            if (!blank) begin
              if (cmd_rule) begin
                sub_mask_nxt = sub_base & sub_hit;
                sub_len_nxt  = sub_inc;
                phase_nxt    = (sub_inc == TOK_CUT) ? ccld_pkg::PH_GAP2 : ccld_pkg::PH_SUB;
              end else begin
                arg_off_nxt = count_r;
                num_nxt     = num_stepped;
                phase_nxt   = ccld_pkg::PH_ARG;
              end
            end
          end
          ccld_pkg::PH_SUB: begin
            if (!blank) begin
              sub_mask_nxt = sub_base & sub_hit;
              sub_len_nxt  = sub_inc;
              phase_nxt    = (sub_inc == TOK_CUT) ? ccld_pkg::PH_GAP2 : ccld_pkg::PH_SUB;
            end else begin
              phase_nxt = ccld_pkg::PH_GAP2;
            end
          end
          ccld_pkg::PH_GAP2: begin
            if (!blank) begin
              arg_off_nxt = count_r;
              num_nxt     = num_stepped;
              phase_nxt   = ccld_pkg::PH_ARG;
            end
          end
          ccld_pkg::PH_ARG: begin
            num_nxt = num_stepped;
          end
          default: phase_nxt = ccld_pkg::PH_LEAD;
        endcase
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ccld_pkg::PH_LEAD;
      prev_cr_r   <= 1'b0;
      overlong_r  <= 1'b0;
      count_r     <= '0;
      lne_r       <= '0;
      arg_off_r   <= '0;
      cmd_len_r   <= '0;
      sub_len_r   <= '0;
      cmd_mask_r  <= '1;
      sub_mask_r  <= '1;
      num_r       <= '{phase: ccld_pkg::NUM_WS, neg: 1'b0, mag: 32'd0};
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      prev_cr_r   <= prev_cr_nxt;
      overlong_r  <= overlong_nxt;
      count_r     <= count_nxt;
      lne_r       <= lne_nxt;
      arg_off_r   <= arg_off_nxt;
      cmd_len_r   <= cmd_len_nxt;
      sub_len_r   <= sub_len_nxt;
      cmd_mask_r  <= cmd_mask_nxt;
      sub_mask_r  <= sub_mask_nxt;
      num_r       <= num_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    outcome_r     <= outcome_nxt;
    arg_present_r <= arg_present_nxt;
    arg_start_r   <= arg_start_nxt;
    arg_length_r  <= arg_length_nxt;
    arg_number_r  <= arg_number_nxt;
    line_length_r <= line_length_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = outcome_r;
  assign out_arg_present = arg_present_r;
  assign out_arg_start   = arg_start_r;
  assign out_arg_length  = arg_length_r;
  assign out_arg_number  = signed'(arg_number_r);
  assign out_line_length = line_length_r;

endmodule

`default_nettype wire
